@@ design/fixed_capacity_array_list_defines.svh @@
// Assertion macros for the list design.
`ifndef FIXED_CAPACITY_ARRAY_LIST_DEFINES_SVH
`define FIXED_CAPACITY_ARRAY_LIST_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled in reset.
`define FCAL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled in reset.
`define FCAL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/fcal_pkg.sv @@
// Types, codes and field widths shared by the list design.
`timescale 1ns / 1ps
package fcal_pkg;

  localparam int CAPACITY_DEF   = 8;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 4;
  localparam int VAL_W  = 32;
  localparam int AMT_W  = 16;
  localparam int STAT_W = 3;
  localparam int IDX_W  = 3;
  localparam int CNT_W  = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_END   = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_END   = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_SEARCH    = 3'd6,
    CMD_ROTATE    = 3'd7
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ACT_HOLD  = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_LEFT  = 2'd2,
    ACT_RIGHT = 2'd3
  } cell_act_t;

  typedef struct packed {
    cell_act_t act;
    logic      cmp_en;
  } cell_ctl_t;

endpackage

@@ design/fcal_if.sv @@
// Request and result channel interfaces of the list.
`timescale 1ns / 1ps
interface fcal_in_if;
  logic                              valid;
  logic                              ready;
  logic [fcal_pkg::CMD_W-1:0]        command;
  logic [fcal_pkg::POS_W-1:0]        position;
  logic signed [fcal_pkg::VAL_W-1:0] value;
  logic [fcal_pkg::AMT_W-1:0]        rotate_amount;

  modport source (output valid, command, position, value, rotate_amount, input ready);
  modport sink   (input valid, command, position, value, rotate_amount, output ready);
endinterface

interface fcal_out_if;
  logic                              valid;
  logic                              ready;
  logic [fcal_pkg::STAT_W-1:0]       status;
  logic signed [fcal_pkg::VAL_W-1:0] removed_value;
  logic [fcal_pkg::IDX_W-1:0]        found_index;
  logic [fcal_pkg::CNT_W-1:0]        entry_count;

  modport source (output valid, status, removed_value, found_index, entry_count, input ready);
  modport sink   (input valid, status, removed_value, found_index, entry_count, output ready);
endinterface

@@ design/fcal_cell.sv @@
// One storage cell of the list: holds a word, shifts with its neighbours, compares to a key.
`timescale 1ns / 1ps
module fcal_cell #(
  parameter int DATA_WIDTH = fcal_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  fcal_pkg::cell_ctl_t   ctl,
  input  logic [DATA_WIDTH-1:0] key,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  match_o
);
  import fcal_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  match_r;

  always_comb begin
    case (ctl.act)
      ACT_LOAD:  data_nxt = key;
      ACT_LEFT:  data_nxt = left_i;
      ACT_RIGHT: data_nxt = right_i;
      default:   data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (ctl.cmp_en) begin
      match_r <= (data_r == key);
    end
  end

  assign data_o  = data_r;
  assign match_o = match_r;

endmodule

@@ design/fcal_mod.sv @@
// Restoring remainder unit: rotate amount modulo the entry count, one bit a cycle.
`timescale 1ns / 1ps
module fcal_mod #(
  parameter int CAPACITY = fcal_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start_i,
  input  logic [fcal_pkg::AMT_W-1:0]          dividend_i,
  input  logic [$clog2(CAPACITY+1)-1:0]       divisor_i,
  output logic                                done_o,
  output logic [$clog2(CAPACITY+1)-1:0]       rem_o
);
  import fcal_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = $clog2(AMT_W);

  logic          busy_r;
  logic          done_r;
  logic [SW-1:0] step_r;
  logic [AMT_W-1:0] num_r;
  logic [CW-1:0] div_r;
  logic [CW-1:0] rem_r;
  logic [CW-1:0] rem_nxt;
  logic [CW:0]   trial;
  logic [CW:0]   diff;

  // bring down the next dividend bit, subtract where it fits
  always_comb begin
    trial = {rem_r, num_r[AMT_W-1]};
    diff  = trial - {1'b0, div_r};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = diff[CW-1:0];
    end else begin
      rem_nxt = trial[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        step_r <= '0;
        num_r  <= dividend_i;
        div_r  <= divisor_i;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        num_r  <= num_r << 1;
        step_r <= step_r + 1'b1;
        if (step_r == SW'(AMT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_r;
  assign rem_o  = rem_r;

endmodule

@@ design/fixed_capacity_array_list.sv @@
// Top level of the fixed-capacity ordered list with insert, delete, search and rotate.
`timescale 1ns / 1ps
`include "fixed_capacity_array_list_defines.svh"
// The list is a row of CAPACITY cells, one word each, with a fill count. One request is
// handled at a time and gives one result. Inserts and deletes shift all cells together in
// the accept cycle; for these and for refused requests the result is then loaded in S_EMIT
// once the output register is free. A search compares in all cells in parallel, then the
// first live match is picked. A rotate has a 16-step remainder unit work out k = amount mod
// count, then the cell ring moves one place right per cycle, k times. A new request is taken
// while the previous result still waits in the output register.
module fixed_capacity_array_list #(
  parameter int CAPACITY   = fcal_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = fcal_pkg::DATA_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  fcal_in_if.sink    in_chan,
  fcal_out_if.source out_chan
);
  import fcal_pkg::*;

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IW  = $clog2(CAPACITY);
  localparam int PCW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MOD,
    S_ROT,
    S_EMIT
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     rot_left_r;
  status_t           res_status_r;
  logic [VAL_W-1:0]  res_removed_r;
  logic [IW-1:0]     res_idx_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [VAL_W-1:0]  out_removed_r;
  logic [IDX_W-1:0]  out_found_r;
  logic [CNT_W-1:0]  out_count_r;

  logic                  fire;
  cmd_t                  cmd;
  logic [PCW-1:0]        pos_x;
  logic [PCW-1:0]        cnt_x;
  logic                  full;
  logic                  empty;
  logic                  ins_ok;
  logic                  del_ok;
  status_t               dec_status;
  logic [CW-1:0]         op_pos;
  logic [CW-1:0]         last_c;
  logic [DATA_WIDTH+VAL_W-1:0] key_ext;
  logic [DATA_WIDTH-1:0] key;
  logic [DATA_WIDTH-1:0] tail;
  logic [DATA_WIDTH-1:0] rm_w;
  logic [VAL_W+DATA_WIDTH-1:0] rm_ext;
  logic                  hit;
  logic [IW-1:0]         hit_idx;
  logic [IW+IDX_W-1:0]   idx_ext;
  logic [CW+CNT_W-1:0]   cnt_ext;
  logic                  mod_start;
  logic                  mod_done;
  logic [CW-1:0]         mod_rem;
  logic                  emit_load;

  logic [DATA_WIDTH-1:0] data_w [CAPACITY];
  logic [CAPACITY-1:0]   match_w;
  cell_ctl_t             ctl_w [CAPACITY];

  assign fire  = in_chan.valid && in_chan.ready;
  assign cmd   = cmd_t'(in_chan.command);
  assign pos_x = PCW'(in_chan.position);
  assign cnt_x = PCW'(count_r);
  assign full  = (count_r == CW'(CAPACITY));
  assign empty = (count_r == '0);

  // stored word is the low DATA_WIDTH bits of the request value
  assign key_ext = {{DATA_WIDTH{1'b0}}, in_chan.value};
  assign key     = key_ext[DATA_WIDTH-1:0];

  assign last_c = count_r - 1'b1;
  assign tail   = data_w[last_c[IW-1:0]];
  assign rm_w   = data_w[op_pos[IW-1:0]];
  assign rm_ext = {{VAL_W{rm_w[DATA_WIDTH-1]}}, rm_w};

  always_comb begin
    ins_ok     = 1'b0;
    del_ok     = 1'b0;
    dec_status = ST_OK;
    op_pos     = '0;
    case (cmd)
      CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT: begin
        if (full) begin
          dec_status = ST_FULL;
        end else if (cmd == CMD_INS_AT && pos_x > cnt_x) begin
          dec_status = ST_BADPOS;
        end else begin
          ins_ok = 1'b1;
          if (cmd == CMD_INS_END) begin
            op_pos = count_r;
          end else if (cmd == CMD_INS_AT) begin
            op_pos = pos_x[CW-1:0];
          end
        end
      end
      CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_AT: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else if (cmd == CMD_DEL_AT && pos_x >= cnt_x) begin
          dec_status = ST_BADPOS;
        end else begin
          del_ok = 1'b1;
          if (cmd == CMD_DEL_END) begin
            op_pos = last_c;
          end else if (cmd == CMD_DEL_AT) begin
            op_pos = pos_x[CW-1:0];
          end
        end
      end
      CMD_SEARCH, CMD_ROTATE: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end
      end
      default: begin
        dec_status = ST_OK;
      end
    endcase
  end

  assign mod_start = fire && (cmd == CMD_ROTATE) && !empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;

    // the head of the row takes the last live entry when the ring turns
    if (i == 0) begin : g_head
      assign left_w = tail;
    end else begin : g_body
      assign left_w = data_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_w = data_w[i];
    end else begin : g_mid
      assign right_w = data_w[i+1];
    end

    always_comb begin
      ctl_w[i].act    = ACT_HOLD;
      ctl_w[i].cmp_en = fire && (cmd == CMD_SEARCH) && !empty;
      if (state_r == S_ROT) begin
        ctl_w[i].act = ACT_LEFT;
      end else if (fire && ins_ok) begin
        if (CW'(i) > op_pos) begin
          ctl_w[i].act = ACT_LEFT;
        end else if (CW'(i) == op_pos) begin
          ctl_w[i].act = ACT_LOAD;
        end
      end else if (fire && del_ok) begin
        if (CW'(i) >= op_pos) begin
          ctl_w[i].act = ACT_RIGHT;
        end
      end
    end

    fcal_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk     (clk),
      .ctl     (ctl_w[i]),
      .key     (key),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (data_w[i]),
      .match_o (match_w[i])
    );
  end

  // first live match wins: scan from the top so the lowest index is kept
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_w[i] && (CW'(i) < count_r)) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  fcal_mod #(.CAPACITY(CAPACITY)) u_mod (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (mod_start),
    .dividend_i (in_chan.rotate_amount),
    .divisor_i  (count_r),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign idx_ext = {{IDX_W{1'b0}}, res_idx_r};
  assign cnt_ext = {{CNT_W{1'b0}}, count_r};

  // hold the result until the output register is free
  assign emit_load = (state_r == S_EMIT) && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (fire) begin
            res_status_r  <= dec_status;
            res_removed_r <= del_ok ? rm_ext[VAL_W-1:0] : '0;
            res_idx_r     <= '0;
            if (ins_ok) begin
              count_r <= count_r + 1'b1;
            end
            if (del_ok) begin
              count_r <= count_r - 1'b1;
            end
            if (cmd == CMD_SEARCH && !empty) begin
              state_r <= S_SEARCH;
            end else if (mod_start) begin
              state_r <= S_MOD;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_SEARCH: begin
          res_status_r <= hit ? ST_OK : ST_NOTFOUND;
          res_idx_r    <= hit_idx;
          state_r      <= S_EMIT;
        end
        S_MOD: begin
          if (mod_done) begin
            if (mod_rem == '0) begin
              state_r <= S_EMIT;
            end else begin
              rot_left_r <= mod_rem;
              state_r    <= S_ROT;
            end
          end
        end
        S_ROT: begin
          rot_left_r <= rot_left_r - 1'b1;
          if (rot_left_r == CW'(1)) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            out_status_r  <= res_status_r;
            out_removed_r <= res_removed_r;
            out_found_r   <= idx_ext[IDX_W-1:0];
            out_count_r   <= cnt_ext[CNT_W-1:0];
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.removed_value = out_removed_r;
  assign out_chan.found_index   = out_found_r;
  assign out_chan.entry_count   = out_count_r;

  `FCAL_ASSERT_NXT(a_accept_leaves_idle, fire, state_r != S_IDLE, "request accepted but still idle")
  `FCAL_ASSERT_IMP(a_rot_bounded, state_r == S_ROT, rot_left_r != '0 && rot_left_r < count_r, "rotate steps out of range")
  `FCAL_ASSERT_NXT(a_count_holds, !fire, $stable(count_r), "count changed without a request")
  `FCAL_ASSERT_IMP(a_out_from_emit, $rose(out_valid_r), $past(state_r) == S_EMIT, "result raised outside emit")

endmodule

@@ bench/tb_fixed_capacity_array_list.sv @@
// Self-checking bench for the fixed-capacity list: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module tb_fixed_capacity_array_list;
  import fcal_pkg::*;

  localparam int LIST_CAP    = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 64;
  localparam int HOLD_AFTER  = 400;
  localparam int HOLD_CYCLES = 200;
  localparam int CALM_TAIL   = 150;
  localparam int RANDOM_REQS = 1550;
  localparam int SHOW_MAX    = 10;

  typedef struct {
    cmd_t                    command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    logic [AMT_W-1:0]        rotate_amount;
  } list_req_t;

  typedef struct {
    status_t                 status;
    logic signed [VAL_W-1:0] removed_value;
    logic [IDX_W-1:0]        found_index;
    logic [CNT_W-1:0]        entry_count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n;

  fcal_in_if  in_chan();
  fcal_out_if out_chan();

  fixed_capacity_array_list u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted list contents
  logic signed [VAL_W-1:0] list_words [LIST_CAP];
  int                      list_count = 0;

  list_req_t    pending_reqs [$];
  list_result_t expected_results [$];

  int unsigned total_reqs   = 0;
  int unsigned reqs_taken   = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count   = 0;
  int unsigned shown        = 0;
  int unsigned send_gap     = 0;
  int unsigned recv_stall   = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  logic        hold_active  = 1'b0;
  int unsigned cycles       = 0;
  int unsigned cmd_seen [8];
  int unsigned status_seen [5];

  function automatic list_result_t apply_list_command(list_req_t req);
    list_result_t            res;
    logic signed [VAL_W-1:0] spun [LIST_CAP];
    int                      slot;
    int                      steps;
    res.status        = ST_OK;
    res.removed_value = '0;
    res.found_index   = '0;
    case (req.command)
      CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT: begin
        // full is checked before the position
        if (list_count >= LIST_CAP) begin
          res.status = ST_FULL;
        end else begin
          if (req.command == CMD_INS_FRONT) slot = 0;
          else if (req.command == CMD_INS_END) slot = list_count;
          else slot = int'(req.position);
          if (slot > list_count) begin
            res.status = ST_BADPOS;
          end else begin
            for (int i = list_count; i > slot; i--) list_words[i] = list_words[i-1];
            list_words[slot] = req.value;
            list_count++;
          end
        end
      end
      CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_AT: begin
        if (list_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (req.command == CMD_DEL_FRONT) slot = 0;
          else if (req.command == CMD_DEL_END) slot = list_count - 1;
          else slot = int'(req.position);
          if (slot >= list_count) begin
            res.status = ST_BADPOS;
          end else begin
            res.removed_value = list_words[slot];
            for (int i = slot; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
            list_count--;
          end
        end
      end
      CMD_SEARCH: begin
        if (list_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_NOTFOUND;
          for (int i = 0; i < list_count; i++) begin
            if (res.status == ST_NOTFOUND && list_words[i] == req.value) begin
              res.status      = ST_OK;
              res.found_index = IDX_W'(i);
            end
          end
        end
      end
      default: begin
        if (list_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          steps = int'(req.rotate_amount) % list_count;
          for (int i = 0; i < list_count; i++) spun[(i + steps) % list_count] = list_words[i];
          for (int i = 0; i < list_count; i++) list_words[i] = spun[i];
        end
      end
    endcase
    res.entry_count = CNT_W'(list_count);
    return res;
  endfunction

  task automatic add_req(cmd_t c, int pos, logic signed [VAL_W-1:0] val, int amt);
    list_req_t r;
    r.command       = c;
    r.position      = POS_W'(pos);
    r.value         = val;
    r.rotate_amount = AMT_W'(amt);
    pending_reqs.push_back(r);
  endtask

  // Driver: offer queued requests, with random gaps except near the end and during the hold
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid         <= 1'b0;
      in_chan.command       <= CMD_INS_FRONT;
      in_chan.position      <= '0;
      in_chan.value         <= '0;
      in_chan.rotate_amount <= '0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        cmd_seen[int'(pending_reqs[0].command)]++;
        expected_results.push_back(apply_list_command(pending_reqs[0]));
        pending_reqs.pop_front();
        reqs_taken++;
      end
      if (in_chan.valid && !in_chan.ready) begin
        // hold the request until it is taken
      end else if (send_gap > 0) begin
        send_gap--;
        in_chan.valid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        in_chan.valid <= 1'b0;
      end else if (!hold_active && reqs_taken + CALM_TAIL < total_reqs &&
                   $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(1, 11) - 1;
        in_chan.valid <= 1'b0;
      end else begin
        in_chan.valid         <= 1'b1;
        in_chan.command       <= pending_reqs[0].command;
        in_chan.position      <= pending_reqs[0].position;
        in_chan.value         <= pending_reqs[0].value;
        in_chan.rotate_amount <= pending_reqs[0].rotate_amount;
      end
    end
  end

  // Monitor: check each result against the oldest prediction and drive ready
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (shown < SHOW_MAX) begin
            shown++;
            $display("ERROR: unexpected result status=%0d removed=%0d index=%0d count=%0d",
                     out_chan.status, out_chan.removed_value, out_chan.found_index,
                     out_chan.entry_count);
          end
        end else begin
          want = expected_results.pop_front();
          status_seen[int'(want.status)]++;
          if (out_chan.status !== want.status || out_chan.removed_value !== want.removed_value ||
              out_chan.found_index !== want.found_index ||
              out_chan.entry_count !== want.entry_count) begin
            fail_count++;
            if (shown < SHOW_MAX) begin
              shown++;
              $display("ERROR: result %0d: status %0d/%0d removed %0d/%0d index %0d/%0d count %0d/%0d (exp/act)",
                       results_seen, want.status, out_chan.status, want.removed_value,
                       out_chan.removed_value, want.found_index, out_chan.found_index,
                       want.entry_count, out_chan.entry_count);
            end
          end
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        // long back-pressure so the block fills up and stalls its input
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_chan.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_chan.ready <= 1'b0;
      end else if (results_seen + CALM_TAIL < total_reqs && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(1, 11) - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
      hold_active <= (hold_left != 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ERROR: timed out after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic signed [VAL_W-1:0] value_pool [12];
    int                      mode;
    int                      r;
    int                      pos;
    int                      amt;
    logic signed [VAL_W-1:0] val;
    cmd_t                    c;

    rst_n = 1'b0;

    // empty list
    add_req(CMD_DEL_FRONT, 0, 0, 0);
    add_req(CMD_DEL_END, 0, 0, 0);
    add_req(CMD_DEL_AT, 0, 0, 0);
    add_req(CMD_SEARCH, 0, 0, 0);
    add_req(CMD_ROTATE, 0, 0, 3);
    add_req(CMD_INS_AT, 1, 7, 0);
    // build up and probe the bounds
    add_req(CMD_INS_AT, 0, 32'sh8000_0000, 0);
    add_req(CMD_INS_FRONT, 0, 32'sh7fff_ffff, 0);
    add_req(CMD_INS_END, 0, 0, 0);
    add_req(CMD_INS_AT, 4, 9, 0);
    add_req(CMD_INS_AT, 3, -1, 0);
    add_req(CMD_SEARCH, 0, 32'sh7fff_ffff, 0);
    add_req(CMD_SEARCH, 0, 12345, 0);
    add_req(CMD_ROTATE, 0, 0, 16'hffff);
    add_req(CMD_ROTATE, 0, 0, 8);
    add_req(CMD_DEL_AT, 4, 0, 0);
    add_req(CMD_DEL_AT, 15, 0, 0);
    for (int i = 1; i <= 4; i++) add_req(CMD_INS_END, 0, i, 0);
    // full list
    add_req(CMD_INS_FRONT, 0, 5, 0);
    add_req(CMD_INS_AT, 9, 6, 0);
    add_req(CMD_INS_END, 0, 7, 0);
    add_req(CMD_SEARCH, 0, 4, 0);
    add_req(CMD_ROTATE, 0, 0, 5);
    add_req(CMD_DEL_AT, 7, 0, 0);
    add_req(CMD_DEL_END, 0, 0, 0);
    add_req(CMD_DEL_FRONT, 0, 0, 0);

    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 0;
    value_pool[3] = -1;
    value_pool[4] = 1;
    for (int i = 5; i < 12; i++) value_pool[i] = $urandom;

    // random phases that lean towards filling, draining or neither
    mode = 2;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 40 == 0) mode = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      if ((mode == 0 && r < 65) || (mode == 1 && r < 20) || (mode == 2 && r < 35)) begin
        c = cmd_t'($urandom_range(int'(CMD_INS_FRONT), int'(CMD_INS_AT)));
      end else if ((mode == 0 && r < 80) || (mode == 1 && r < 75) || (mode == 2 && r < 70)) begin
        c = cmd_t'($urandom_range(int'(CMD_DEL_FRONT), int'(CMD_DEL_AT)));
      end else if (r < 88) begin
        c = CMD_SEARCH;
      end else begin
        c = CMD_ROTATE;
      end
      pos = ($urandom_range(0, 99) < 85) ? $urandom_range(0, LIST_CAP) : $urandom_range(9, 15);
      val = ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, 11)] : $urandom;
      r = $urandom_range(0, 9);
      if (r < 5) amt = $urandom_range(0, 17);
      else if (r < 9) amt = $urandom_range(0, 16'hffff);
      else amt = 16'hffff;
      add_req(c, pos, val, amt);
    end
    total_reqs = pending_reqs.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (expected_results.size() != 0) begin
      fail_count++;
      $display("ERROR: %0d results never arrived", expected_results.size());
    end
    $display("Summary: %0d requests, %0d results; per command ins %0d/%0d/%0d del %0d/%0d/%0d search %0d rotate %0d",
             reqs_taken, results_seen, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3],
             cmd_seen[4], cmd_seen[5], cmd_seen[6], cmd_seen[7]);
    $display("Statuses: ok %0d, full %0d, empty %0d, bad position %0d, not found %0d; %0d failures",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
             fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
